// ===== rtl/core/lis_length_patience_tails_unit_defines.svh =====
// assertion macros shared by the lis tails unit modules
// needs clk and rst in scope at the point of use
`ifndef LIS_LENGTH_PATIENCE_TAILS_UNIT_DEFINES_SVH
`define LIS_LENGTH_PATIENCE_TAILS_UNIT_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define LPT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition that holds in the cycle after a trigger
`define LPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lpt_pkg.sv =====
// shared constants and types for the lis tails unit
// no dependencies
`timescale 1ns / 1ps

package lpt_pkg;

  localparam int TAILS_DEPTH_DEF = 1024;
  localparam int VALUE_W = 32;
  localparam int LENGTH_W = 11;

  // flipping the sign bit makes signed order match unsigned order
  localparam logic [VALUE_W-1:0] SIGN_FLIP = 32'h8000_0000;

  typedef struct packed {
    logic done;
    logic append;
  } search_stat_t;

endpackage

// ===== rtl/core/lpt_ifs.sv =====
// valid/ready channel interfaces for the lis tails unit
// depends on lpt_pkg for field widths
`timescale 1ns / 1ps

interface lpt_item_if;
  logic                               valid;
  logic                               ready;
  logic signed [lpt_pkg::VALUE_W-1:0] value;
  logic                               last;

  modport source (output valid, value, last, input ready);
  modport sink (input valid, value, last, output ready);
endinterface

interface lpt_result_if;
  logic                          valid;
  logic                          ready;
  logic [lpt_pkg::LENGTH_W-1:0]  length;
  logic                          overflow;
  logic                          final_res;

  modport source (output valid, length, overflow, final_res, input ready);
  modport sink (input valid, length, overflow, final_res, output ready);
endinterface

// ===== rtl/core/lpt_tails_mem.sv =====
// tails store: one write port, one registered read port
// depends on lpt_pkg for the data width
`timescale 1ns / 1ps

module lpt_tails_mem #(
  parameter int TAILS_DEPTH = lpt_pkg::TAILS_DEPTH_DEF,
  localparam int AW = (TAILS_DEPTH > 1) ? $clog2(TAILS_DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [lpt_pkg::VALUE_W-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [lpt_pkg::VALUE_W-1:0] rdata
);

  logic [lpt_pkg::VALUE_W-1:0] mem [TAILS_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/lpt_search.sv =====
// binary search for the first tail not less than the key
// one compare after each read step against the tails store; depends on lpt_pkg
`timescale 1ns / 1ps

`include "lis_length_patience_tails_unit_defines.svh"

module lpt_search #(
  parameter int TAILS_DEPTH = lpt_pkg::TAILS_DEPTH_DEF,
  localparam int CW = $clog2(TAILS_DEPTH + 1),
  localparam int AW = (TAILS_DEPTH > 1) ? $clog2(TAILS_DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lpt_pkg::VALUE_W-1:0] key,
  input  logic [CW-1:0]               count,
  output logic [AW-1:0]               rd_addr,
  input  logic [lpt_pkg::VALUE_W-1:0] rd_data,
  output logic [CW-1:0]               pos,
  output lpt_pkg::search_stat_t       stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;

  logic [1:0]    state;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [CW-1:0] mid;
  logic [CW-1:0] span;

  assign span = hi - lo;
  assign mid = lo + (span >> 1);
  assign rd_addr = mid[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (start) state <= S_READ;
        S_READ: state <= (lo == hi) ? S_IDLE : S_CMP;
        S_CMP:  state <= S_READ;
        default: state <= S_IDLE;
      endcase
    end
  end

  // store data for mid arrives in the compare cycle
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      lo <= '0;
      hi <= count;
    end else if (state == S_CMP) begin
      if (rd_data < key) begin
        lo <= mid + CW'(1);
      end else begin
        hi <= mid;
      end
    end
  end

  assign pos = lo;
  assign stat.done = (state == S_READ) && (lo == hi);
  assign stat.append = (lo == count);

  `LPT_ASSERT_ALWAYS(a_bounds_ordered, state == S_IDLE || lo <= hi, "search bounds crossed")
  `LPT_ASSERT_ALWAYS(a_hi_in_range, state == S_IDLE || hi <= count, "search upper bound past count")
  `LPT_ASSERT_NEXT(a_start_idle, start, state != S_IDLE || $past(state) != S_IDLE, "start ignored")

endmodule

// ===== rtl/core/lis_length_patience_tails_unit.sv =====
// Longest strictly increasing subsequence length, patience (tails) method.
// Channels: item (sink) carries value and last; result (source) carries length,
// overflow and final_res. Every item beat gives exactly one result beat.
// Each item binary-searches the sorted tails store, then replaces the found
// tail or appends. The search unit alternates a read step and a compare step
// through the store's single registered read port.
// Each search takes at most ceil(log2(n+1)) halving steps for n stored tails
// (up to 11 with 1024 tails); one item is in work at a time, and the next
// item beat is not taken until the block is through with the last one.
// item.ready is high only while no item is in work; a finished result waits in
// the output register, and a new item may be taken while it waits.
// If result is stalled when the next result is ready, the block holds in its
// finish step and writes nothing until the output register frees.
// A last beat answers for its item, then clears length and overflow.
// Full store: an append is dropped and overflow stays set to sequence end.
// Reset (rst, synchronous) empties the store and clears the output; tails data
// need no clearing since only entries below the count are ever compared.
`timescale 1ns / 1ps

`include "lis_length_patience_tails_unit_defines.svh"

module lis_length_patience_tails_unit #(
  parameter int TAILS_DEPTH = lpt_pkg::TAILS_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  lpt_item_if.sink            item,
  lpt_result_if.source        result
);

  localparam int CW = $clog2(TAILS_DEPTH + 1);
  localparam int AW = (TAILS_DEPTH > 1) ? $clog2(TAILS_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TAILS_DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                  state;
  logic [lpt_pkg::VALUE_W-1:0] key;
  logic                        last;
  logic [CW-1:0]               count;
  logic                        ovf;
  logic                        append;
  logic [CW-1:0]               pos;

  logic                        res_valid;
  logic [lpt_pkg::LENGTH_W-1:0] res_length;
  logic                        res_overflow;
  logic                        res_final;

  logic                        accept;
  logic                        slot_free;
  logic                        commit;
  logic                        full;
  logic [CW-1:0]               count_next;
  logic                        ovf_next;
  logic                        we;

  logic [AW-1:0]               rd_addr;
  logic [lpt_pkg::VALUE_W-1:0] rd_data;
  logic [CW-1:0]               srch_pos;
  lpt_pkg::search_stat_t       srch_stat;

  assign item.ready = (state == ST_IDLE);
  assign accept = item.valid && item.ready;
  assign slot_free = !res_valid || result.ready;
  assign commit = (state == ST_FINISH) && slot_free;
  assign full = (count == DEPTH_C);

  always_comb begin
    count_next = count;
    ovf_next = ovf;
    if (append) begin
      if (full) begin
        ovf_next = 1'b1;
      end else begin
        count_next = count + CW'(1);
      end
    end
  end

  // on append pos equals count, so one address serves both cases
  assign we = commit && !(append && full);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE:   if (accept) state <= ST_SEARCH;
        ST_SEARCH: if (srch_stat.done) state <= ST_FINISH;
        ST_FINISH: if (slot_free) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key <= lpt_pkg::VALUE_W'(item.value) ^ lpt_pkg::SIGN_FLIP;
      last <= item.last;
    end
    if (state == ST_SEARCH && srch_stat.done) begin
      append <= srch_stat.append;
      pos <= srch_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf <= 1'b0;
    end else if (commit) begin
      count <= last ? '0 : count_next;
      ovf <= last ? 1'b0 : ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_length <= lpt_pkg::LENGTH_W'(count_next);
      res_overflow <= ovf_next;
      res_final <= last;
    end
  end

  assign result.valid = res_valid;
  assign result.length = res_length;
  assign result.overflow = res_overflow;
  assign result.final_res = res_final;

  // the search compares in later cycles, so it takes the held key
  lpt_search #(
    .TAILS_DEPTH (TAILS_DEPTH)
  ) u_search (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .key     (key),
    .count   (count),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .pos     (srch_pos),
    .stat    (srch_stat)
  );

  lpt_tails_mem #(
    .TAILS_DEPTH (TAILS_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (pos[AW-1:0]),
    .wdata (key),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  `LPT_ASSERT_ALWAYS(a_count_bound, count <= DEPTH_C, "tails count past depth")
  `LPT_ASSERT_ALWAYS(a_ovf_full, !ovf || full, "overflow set with store not full")
  `LPT_ASSERT_NEXT(a_accept_search, accept, state == ST_SEARCH, "accepted beat did not start search")
  `LPT_ASSERT_ALWAYS(a_pos_in_range, state != ST_FINISH || pos <= count, "search position past count")

endmodule

// ===== dv/tb.sv =====
// testbench for lis_length_patience_tails_unit: directed and random sequences
// uses lpt_pkg, lpt_item_if and lpt_result_if from the rtl; a tracker class models the tails
`timescale 1ns / 1ps

module tb;

  localparam int STORE_DEPTH = lpt_pkg::TAILS_DEPTH_DEF;
  localparam int VAL_MIN = 32'sh8000_0000;
  localparam int VAL_MAX = 32'sh7FFF_FFFF;
  localparam int TOTAL_ITEMS = 850;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [lpt_pkg::LENGTH_W-1:0] length;
    logic                         overflow;
    logic                         final_res;
  } lis_answer_t;

  class lis_length_tracker;
    int          tails[STORE_DEPTH];
    int          tails_used;
    bit          dropped;
    lis_answer_t lengths_due[$];
    int unsigned errors, items_seen, seqs_done, longest, drops;

    function new();
      tails_used = 0;
      dropped = 1'b0;
      errors = 0;
      items_seen = 0;
      seqs_done = 0;
      longest = 0;
      drops = 0;
    endfunction

    // update the tails for one accepted item and queue its answer
    function void note_value(logic signed [lpt_pkg::VALUE_W-1:0] value, logic last);
      int lo, hi, mid;
      lis_answer_t a;
      if (tails_used == 0 || value > tails[tails_used-1]) begin
        if (tails_used < STORE_DEPTH) begin
          tails[tails_used] = value;
          tails_used++;
        end else begin
          dropped = 1'b1;
          drops++;
        end
      end else begin
        // first tail not less than the value
        lo = 0;
        hi = tails_used;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (tails[mid] < value) lo = mid + 1;
          else hi = mid;
        end
        tails[lo] = value;
      end
      a.length = tails_used[lpt_pkg::LENGTH_W-1:0];
      a.overflow = dropped;
      a.final_res = last;
      lengths_due = {lengths_due, a};
      items_seen++;
      if (tails_used > longest) longest = tails_used;
      if (last) begin
        tails_used = 0;
        dropped = 1'b0;
        seqs_done++;
      end
    endfunction

    function void check_answer(logic [lpt_pkg::LENGTH_W-1:0] length, logic overflow,
                               logic final_res);
      lis_answer_t want, got;
      got.length = length;
      got.overflow = overflow;
      got.final_res = final_res;
      if (lengths_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: length %0d overflow %0b final_res %0b",
                   length, overflow, final_res);
        return;
      end
      want = lengths_due.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected length %0d overflow %0b final_res %0b, got %0d %0b %0b",
                   want.length, want.overflow, want.final_res,
                   got.length, got.overflow, got.final_res);
      end
    endfunction

    function int pending();
      return lengths_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;

  lis_length_tracker tracker = new();

  lpt_item_if   item_if ();
  lpt_result_if result_if ();

  lis_length_patience_tails_unit #(
    .TAILS_DEPTH(STORE_DEPTH)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #6_000_000;
    $display("Mismatches found");
    $finish;
  end

  // one item beat; valid stays high when the next item follows without a gap
  task automatic send_item(int v, bit lst);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.value <= v;
    item_if.last <= lst;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    tracker.note_value(v, lst);
  endtask

  task automatic wait_drain();
    item_if.valid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
  endtask

  function automatic int extreme_value();
    case ($urandom_range(0, 6))
      0: return VAL_MIN;
      1: return VAL_MIN + 1;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return VAL_MAX - 1;
      default: return VAL_MAX;
    endcase
  endfunction

  task automatic send_random_sequence();
    int len, mode, walk, v;
    mode = $urandom_range(0, 4);
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
    walk = $urandom_range(0, 2000000) - 1000000;
    tx_calm = ($urandom_range(0, 3) == 0);
    rx_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: v = $urandom;
        1: v = $urandom_range(0, 16) - 8;  // many equal values
        2: begin
          walk += $urandom_range(0, 64) - 16;
          v = walk;
        end
        3: begin
          walk -= $urandom_range(0, 64) - 16;
          v = walk;
        end
        default: v = $urandom_range(0, 1) ? extreme_value() : $urandom;
      endcase
      send_item(v, i == len - 1);
    end
  endtask

  // receiver: stalls for a random count after each accepted beat unless rx_calm is set
  initial begin
    int stall;
    stall = 0;
    result_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        stall--;
      end else begin
        result_if.ready <= 1'b1;
      end
      @(posedge clk);
      if (result_if.valid && result_if.ready) begin
        tracker.check_answer(result_if.length, result_if.overflow, result_if.final_res);
        stall = rx_calm ? 0 : $urandom_range(0, 9);
      end
    end
  end

  initial begin
    item_if.valid <= 1'b0;
    item_if.value <= '0;
    item_if.last <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // single-item sequences from an empty store
    send_item(VAL_MIN, 1'b1);
    send_item(VAL_MAX, 1'b1);
    // appends across the whole range, then equal and smaller values replace, and a last value appends
    send_item(VAL_MIN, 1'b0);
    send_item(-1, 1'b0);
    send_item(0, 1'b0);
    send_item(1, 1'b0);
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b0);
    send_item(0, 1'b0);
    send_item(32'h5555_5555, 1'b0);
    send_item(32'hAAAA_AAAA, 1'b0);
    send_item(VAL_MAX - 1, 1'b1);
    // falling sequence with a repeat
    send_item(100, 1'b0);
    send_item(50, 1'b0);
    send_item(50, 1'b0);
    send_item(-50, 1'b0);
    send_item(-51, 1'b1);
    wait_drain();

    while (tracker.items_seen < TOTAL_ITEMS) begin
      send_random_sequence();
      if ($urandom_range(0, 39) == 0) wait_drain();
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d items in %0d sequences, longest length %0d, %0d dropped appends",
             tracker.items_seen, tracker.seqs_done, tracker.longest, tracker.drops);
    $display("%0d result mismatches, %0d answers left over",
             tracker.errors, tracker.pending());
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
